[rtl/fifo_evict_key_value_cache_assert.svh]
// ----------------------------------------------------------------------------
// fifo evict key/value cache assertion macros
// property wrappers used by the cache rtl
// ----------------------------------------------------------------------------
`ifndef FIFO_EVICT_KEY_VALUE_CACHE_ASSERT_SVH
`define FIFO_EVICT_KEY_VALUE_CACHE_ASSERT_SVH

// same-cycle implication
`define FEC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fec_pkg.sv]
// ----------------------------------------------------------------------------
// fec_pkg
// command codes, field widths and cell control type of the cache
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fec_pkg;

    localparam int CMD_W         = 2;
    localparam int KEY_FIELD_W   = 56;
    localparam int KEY_FIELD_BYTES = KEY_FIELD_W / 8;
    localparam int VALUE_FIELD_W = 32;
    localparam int COUNT_FIELD_W = 5;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd2;

    typedef struct packed {
        logic shift;
        logic load_key;
        logic load_val;
    } fec_cell_ctrl_t;

endpackage

[rtl/fifo_evict_key_value_cache.sv]
// ----------------------------------------------------------------------------
// fifo_evict_key_value_cache
// fully associative key/value cache with oldest-first replacement
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries command, key and value;
//   output channel (out_valid / out_stall) returns found, value_out and
//   entry_count, one result transaction per input transaction.
//   slots form a chain of cells; slot 0 holds the oldest entry and a drop
//   shifts every cell down by one at once.
//   each transaction is accepted in the idle state, which registers the
//   normalized key; the execute state then does the parallel compare across
//   all cells and the update of the chain, and a new transaction is taken
//   only after the block leaves the execute state.
//   in_stall is high in the execute state; the next transaction can be
//   taken while a result waits in the output register.
//   if out_stall holds a result, execution of the next transaction waits
//   until the output register frees.
//   reset empties the cache (entry count zero), clears out_valid and returns to idle; slot
//   contents are not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fifo_evict_key_value_cache_assert.svh"

module fifo_evict_key_value_cache #(
    parameter int SLOTS      = 16,
    parameter int KEY_BYTES  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fec_pkg::CMD_W-1:0]         command,
    input  logic [fec_pkg::KEY_FIELD_W-1:0]   key,
    input  logic [fec_pkg::VALUE_FIELD_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found,
    output logic [fec_pkg::VALUE_FIELD_W-1:0] value_out,
    output logic [fec_pkg::COUNT_FIELD_W-1:0] entry_count
);
    import fec_pkg::*;

    localparam int KEEP_BYTES = (KEY_BYTES - 1 < KEY_FIELD_BYTES) ? KEY_BYTES - 1
                                                                  : KEY_FIELD_BYTES;
    localparam int KEY_W = 8 * KEEP_BYTES;
    localparam int VAL_W = (VALUE_BITS < VALUE_FIELD_W) ? VALUE_BITS : VALUE_FIELD_W;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    // bytes after the first zero byte are dropped, at most KEEP_BYTES kept
    function automatic logic [KEY_FIELD_W-1:0] normalize(input logic [KEY_FIELD_W-1:0] raw);
        logic [KEY_FIELD_W-1:0] k;
        logic                   alive;
        k     = '0;
        alive = 1'b1;
        for (int i = 0; i < KEY_FIELD_BYTES; i++)
        begin
            if (i >= KEEP_BYTES || raw[8*i +: 8] == 8'h00)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                k[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return k;
    endfunction

    logic [0:0]               state_reg;
    logic [0:0]               state_next;
    logic [CMD_W-1:0]         cmd_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [VAL_W-1:0]         val_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     found_reg;
    logic                     found_next;
    logic [VALUE_FIELD_W-1:0] value_out_reg;
    logic [VALUE_FIELD_W-1:0] value_out_next;
    logic [CNT_W-1:0]         count_out_reg;

    logic [KEY_FIELD_W-1:0]   norm_key;
    logic                     in_take;
    logic                     exec_go;
    logic                     hit;
    logic                     full;
    logic                     do_shift;
    logic                     do_append;
    logic                     do_replace;
    logic [CNT_W-1:0]         append_idx;
    logic [VAL_W-1:0]         hit_val;
    logic [SLOTS-1:0]         match_vec;
    logic [KEY_W-1:0]         cell_key [SLOTS];
    logic [VAL_W-1:0]         cell_val [SLOTS];
    fec_cell_ctrl_t           cell_ctrl [SLOTS];
    logic [CNT_W+COUNT_FIELD_W-1:0] count_wide;

    assign norm_key = normalize(key);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign exec_go  = (state_reg == ST_EXEC) && !(out_valid_reg && out_stall);

    // chain of slots, each takes its younger neighbor on a shift
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_slot
        logic [KEY_W-1:0] nbr_key;
        logic [VAL_W-1:0] nbr_val;
        if (g == SLOTS - 1)
        begin : g_tail
            assign nbr_key = key_reg;
            assign nbr_val = val_reg;
        end
        else
        begin : g_body
            assign nbr_key = cell_key[g+1];
            assign nbr_val = cell_val[g+1];
        end

        always_comb
        begin
            cell_ctrl[g].shift    = do_shift;
            cell_ctrl[g].load_key = do_append && (append_idx == CNT_W'(g));
            cell_ctrl[g].load_val = (do_append && (append_idx == CNT_W'(g)))
                                 || (do_replace && match_vec[g]);
        end

        fec_cell #(
            .KEY_W (KEY_W),
            .VAL_W (VAL_W)
        ) u_cell (
            .clk     (clk),
            .live    (CNT_W'(g) < count_reg),
            .ctrl    (cell_ctrl[g]),
            .cmp_key (key_reg),
            .new_key (key_reg),
            .new_val (val_reg),
            .nbr_key (nbr_key),
            .nbr_val (nbr_val),
            .key_out (cell_key[g]),
            .val_out (cell_val[g]),
            .match   (match_vec[g])
        );
    end

    // keys are unique, so an or over the matching cells selects the hit value
    always_comb
    begin
        hit_val = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (match_vec[i])
            begin
                hit_val = hit_val | cell_val[i];
            end
        end
    end

    assign hit  = |match_vec;
    assign full = (count_reg == CNT_W'(SLOTS));

    always_comb
    begin
        do_shift       = 1'b0;
        do_append      = 1'b0;
        do_replace     = 1'b0;
        append_idx     = full ? CNT_W'(SLOTS - 1) : count_reg;
        count_next     = count_reg;
        found_next     = 1'b0;
        value_out_next = '0;
        if (exec_go)
        begin
            case (cmd_reg)
                CMD_LOOKUP:
                begin
                    found_next     = hit;
                    value_out_next = VALUE_FIELD_W'(hit_val);
                end
                CMD_PUT:
                begin
                    if (hit)
                    begin
                        do_replace     = 1'b1;
                        found_next     = 1'b1;
                        value_out_next = VALUE_FIELD_W'(hit_val);
                    end
                    else
                    begin
                        do_append = 1'b1;
                        if (full)
                        begin
                            // evict the oldest entry to make room
                            do_shift       = 1'b1;
                            found_next     = 1'b1;
                            value_out_next = VALUE_FIELD_W'(cell_val[0]);
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                CMD_TAKE:
                begin
                    if (count_reg != '0)
                    begin
                        do_shift       = 1'b1;
                        found_next     = 1'b1;
                        value_out_next = VALUE_FIELD_W'(cell_val[0]);
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    found_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= command;
            key_reg <= norm_key[KEY_W-1:0];
            val_reg <= value[VAL_W-1:0];
        end
        if (exec_go)
        begin
            found_reg     <= found_next;
            value_out_reg <= value_out_next;
            count_out_reg <= count_next;
        end
    end

    assign count_wide  = (CNT_W + COUNT_FIELD_W)'(count_out_reg);
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign value_out   = value_out_reg;
    assign entry_count = count_wide[COUNT_FIELD_W-1:0];

    `FEC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(SLOTS), "entry count above slot count")
    `FEC_ASSERT_NOW(a_unique_match, clk, rst_n, state_reg == ST_EXEC, $onehot0(match_vec), "key held in more than one slot")
    `FEC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_take, in_stall, "transaction taken while executing")
    `FEC_ASSERT_NEXT(a_take_found, clk, rst_n, exec_go && cmd_reg == CMD_TAKE && count_reg != '0, out_valid && found, "take on a non-empty cache lost its entry")

endmodule

[rtl/fec_cell.sv]
// ----------------------------------------------------------------------------
// fec_cell
// one slot of the cache: key and value storage, key compare, shift from the
// younger neighbor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fec_cell #(
    parameter int KEY_W = 56,
    parameter int VAL_W = 32
) (
    input  logic                    clk,
    input  logic                    live,
    input  fec_pkg::fec_cell_ctrl_t ctrl,
    input  logic [KEY_W-1:0]        cmp_key,
    input  logic [KEY_W-1:0]        new_key,
    input  logic [VAL_W-1:0]        new_val,
    input  logic [KEY_W-1:0]        nbr_key,
    input  logic [VAL_W-1:0]        nbr_val,
    output logic [KEY_W-1:0]        key_out,
    output logic [VAL_W-1:0]        val_out,
    output logic                    match
);
    import fec_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.load_key)
        begin
            key_next = new_key;
        end
        else if (ctrl.shift)
        begin
            key_next = nbr_key;
        end
        val_next = val_reg;
        if (ctrl.load_val)
        begin
            val_next = new_val;
        end
        else if (ctrl.shift)
        begin
            val_next = nbr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

    assign match   = live && (key_reg == cmp_key);
    assign key_out = key_reg;
    assign val_out = val_reg;

endmodule

[tb/fec_reply_checker.sv]
// ----------------------------------------------------------------------------
// fec_reply_checker
// watches both channels of the fifo evict key/value cache, keeps its own
// copy of the slot chain, predicts each reply and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fec_reply_checker #(
    parameter int SLOTS      = 16,
    parameter int KEY_BYTES  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [fec_pkg::CMD_W-1:0]         command,
    input  logic [fec_pkg::KEY_FIELD_W-1:0]   key,
    input  logic [fec_pkg::VALUE_FIELD_W-1:0] value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              found,
    input  logic [fec_pkg::VALUE_FIELD_W-1:0] value_out,
    input  logic [fec_pkg::COUNT_FIELD_W-1:0] entry_count,
    output int                                mismatches,
    output int                                outstanding
);

    import fec_pkg::*;

    localparam logic [VALUE_FIELD_W-1:0] VALUE_MASK =
        (VALUE_BITS >= VALUE_FIELD_W) ? '1 : VALUE_FIELD_W'((64'd1 << VALUE_BITS) - 64'd1);

    typedef struct packed {
        logic                     hit;
        logic [VALUE_FIELD_W-1:0] data;
        logic [COUNT_FIELD_W-1:0] count;
    } cache_reply_t;

    logic [KEY_FIELD_W-1:0]   slot_key [SLOTS];
    logic [VALUE_FIELD_W-1:0] slot_val [SLOTS];
    int                       live_entries;
    cache_reply_t             reply_q[$];

    assign outstanding = reply_q.size();

    // keep bytes up to the first zero byte, at most KEY_BYTES-1 of them
    function automatic logic [KEY_FIELD_W-1:0] trim_key(input logic [KEY_FIELD_W-1:0] raw);
        logic [KEY_FIELD_W-1:0] k;
        logic                   ended;
        k = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES - 1 && i < KEY_FIELD_BYTES; i++)
        begin
            if (raw[8*i +: 8] == 8'd0)
                ended = 1'b1;
            if (!ended)
                k[8*i +: 8] = raw[8*i +: 8];
        end
        return k;
    endfunction

    function automatic logic [VALUE_FIELD_W-1:0] drop_oldest();
        logic [VALUE_FIELD_W-1:0] v;
        v = slot_val[0];
        for (int i = 1; i < live_entries && i < SLOTS; i++)
        begin
            slot_key[i-1] = slot_key[i];
            slot_val[i-1] = slot_val[i];
        end
        live_entries--;
        return v;
    endfunction

    function automatic cache_reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [KEY_FIELD_W-1:0] raw_key,
                                                   input logic [VALUE_FIELD_W-1:0] new_val);
        cache_reply_t           r;
        logic [KEY_FIELD_W-1:0] k;
        int                     idx;
        r = '0;
        k = trim_key(raw_key);
        idx = -1;
        for (int i = 0; i < live_entries && i < SLOTS; i++)
            if (idx < 0 && slot_key[i] == k)
                idx = i;
        case (cmd)
            CMD_LOOKUP:
            begin
                if (idx >= 0)
                begin
                    r.hit = 1'b1;
                    r.data = slot_val[idx];
                end
            end
            CMD_PUT:
            begin
                if (idx >= 0)
                begin
                    r.hit = 1'b1;
                    r.data = slot_val[idx];
                    slot_val[idx] = new_val & VALUE_MASK;
                end
                else
                begin
                    // full store: oldest entry makes room for the new one
                    if (live_entries >= SLOTS)
                    begin
                        r.hit = 1'b1;
                        r.data = drop_oldest();
                    end
                    slot_key[live_entries] = k;
                    slot_val[live_entries] = new_val & VALUE_MASK;
                    live_entries++;
                end
            end
            CMD_TAKE:
            begin
                if (live_entries > 0)
                begin
                    r.hit = 1'b1;
                    r.data = drop_oldest();
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_FIELD_W'(live_entries);
        return r;
    endfunction

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cache_reply_t want;
        if (!rst_n)
        begin
            live_entries = 0;
            reply_q.delete();
        end
        else
        begin
            // a reply can never belong to the transaction accepted at this edge
            if (out_valid && !out_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    $display("%0t: unexpected reply, expected none actual found=%b value_out=%h entry_count=%0d",
                             $time, found, value_out, entry_count);
                    mismatches++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (found !== want.hit)
                        report_field("found", 64'(want.hit), 64'(found));
                    if (value_out !== want.data)
                        report_field("value_out", 64'(want.data), 64'(value_out));
                    if (entry_count !== want.count)
                        report_field("entry_count", 64'(want.count), 64'(entry_count));
                end
            end
            if (in_valid && !in_stall)
                reply_q.push_back(apply_command(command, key, value));
        end
    end

endmodule

[tb/tb_fifo_evict_key_value_cache.sv]
// ----------------------------------------------------------------------------
// tb_fifo_evict_key_value_cache
// drives directed and random cache commands with random idle and stall
// patterns; a checker beside the block predicts and compares every reply
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fifo_evict_key_value_cache;

    import fec_pkg::*;

    localparam int SLOTS       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 330;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     out_stall = 1'b0;
    logic [CMD_W-1:0]         command   = CMD_LOOKUP;
    logic [KEY_FIELD_W-1:0]   key       = '0;
    logic [VALUE_FIELD_W-1:0] value     = '0;
    logic                     in_stall;
    logic                     out_valid;
    logic                     found;
    logic [VALUE_FIELD_W-1:0] value_out;
    logic [COUNT_FIELD_W-1:0] entry_count;

    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int mismatches;
    int outstanding;

    logic [KEY_FIELD_W-1:0] key_pool [POOL_SIZE];

    always #5 clk = ~clk;

    fifo_evict_key_value_cache #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .key(key),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .value_out(value_out),
        .entry_count(entry_count)
    );

    fec_reply_checker #(
        .SLOTS(SLOTS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .key(key),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .value_out(value_out),
        .entry_count(entry_count),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_FIELD_W-1:0] k,
                             input logic [VALUE_FIELD_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        key <= k;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // pool keys, sometimes with junk after the terminator, sometimes fully random
    function automatic logic [KEY_FIELD_W-1:0] pick_key();
        logic [KEY_FIELD_W-1:0] k;
        int                     len;
        if ($urandom_range(9) == 0)
            return KEY_FIELD_W'({$urandom, $urandom});
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
        len = 0;
        while (len < KEY_FIELD_BYTES && k[8*len +: 8] != 8'd0)
            len++;
        if (len < KEY_FIELD_BYTES && $urandom_range(3) == 0)
            for (int i = len + 1; i < KEY_FIELD_BYTES; i++)
                k[8*i +: 8] = 8'($urandom);
        return k;
    endfunction

    function automatic logic [VALUE_FIELD_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return CMD_PUT;
        else if (r < 80)
            return CMD_LOOKUP;
        else if (r < 95)
            return CMD_TAKE;
        return CMD_UNUSED;
    endfunction

    initial
    begin
        int len;
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            key_pool[p] = '0;
            len = $urandom_range(KEY_FIELD_BYTES);
            for (int i = 0; i < len; i++)
                key_pool[p][8*i +: 8] = 8'($urandom_range(255, 1));
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(CMD_TAKE, '0, '0);
        send_item(CMD_LOOKUP, '1, '1);
        send_item(CMD_UNUSED, 56'h12_3456_789A_BCDE, 32'hDEAD_BEEF);
        // empty key holding a zero value
        send_item(CMD_PUT, '0, '0);
        send_item(CMD_LOOKUP, 56'hFF_FFFF_FFFF_FF00, '1);
        send_item(CMD_PUT, '1, '1);
        send_item(CMD_PUT, 56'h5A_00C3_0000_4241, 32'h0000_00A5);
        send_item(CMD_LOOKUP, 56'h00_0000_0000_4241, '0);
        send_item(CMD_PUT, '1, 32'h8000_0001);
        // fill the store, then one more put evicts the oldest (empty key)
        for (int i = 0; i < SLOTS - 3; i++)
            send_item(CMD_PUT, 56'h11_2233_4455_6600 | KEY_FIELD_W'(i + 1), 32'(i * 7 + 3));
        send_item(CMD_PUT, 56'h77_6655_4433_2211, 32'h1234_5678);
        send_item(CMD_TAKE, '0, '0);
        send_item(CMD_LOOKUP, '0, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 65 : 0;
            recv_stall_pct = (phase == 0) ? 65 : (phase == 1) ? 33 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                begin
                    // hold off until every reply is back
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (outstanding != 0)
                        @(negedge clk);
                end
                if ($urandom_range(99) == 0)
                    repeat (SLOTS + 1) send_item(CMD_TAKE, pick_key(), pick_value());
                else
                    send_item(pick_command(), pick_key(), pick_value());
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[fifo_evict_key_value_cache.f]
+incdir+rtl
rtl/fec_pkg.sv
rtl/fec_cell.sv
rtl/fifo_evict_key_value_cache.sv
tb/fec_reply_checker.sv
tb/tb_fifo_evict_key_value_cache.sv
